/* hw/rtl/c2ns_pkg.sv */
package c2ns_pkg;

	localparam int CW = 20;
	localparam int FB = 16;
	localparam int CS = 18;
	localparam int RW = FB + 5;
	localparam int AW = FB + 1;
	localparam int SQW = 2 * CW;
	localparam int SW = 2 * CW + 2;
	localparam int REMW = RW + 2;
	localparam int CXW = 64;
	localparam int ZW = 34;
	localparam int SCALE = 60 - CW;
	localparam int NST = 3 + RW;
	localparam int CEND = 2 + CS;

	localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'sd1 << 30);
	localparam logic signed [ZW-1:0] Z_ONE = ZW'(64'sd1 << 31);
	localparam logic [ZW-1:0] Z_RND = ZW'(64'd1 << (30 - FB));
	localparam logic [AW-1:0] ANG_ONE = AW'(1) << FB;
	localparam logic [AW-1:0] ANG_HALF = AW'(1) << (FB - 1);

	function automatic logic signed [ZW-1:0] arc_tab(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 34'sd536870912;
			1: v = 34'sd316933406;
			2: v = 34'sd167458907;
			3: v = 34'sd85004756;
			4: v = 34'sd42667331;
			5: v = 34'sd21354465;
			6: v = 34'sd10679838;
			7: v = 34'sd5340245;
			8: v = 34'sd2670163;
			9: v = 34'sd1335087;
			10: v = 34'sd667544;
			11: v = 34'sd333772;
			12: v = 34'sd166886;
			13: v = 34'sd83443;
			14: v = 34'sd41722;
			15: v = 34'sd20861;
			16: v = 34'sd10430;
			17: v = 34'sd5215;
			18: v = 34'sd2608;
			19: v = 34'sd1304;
			20: v = 34'sd652;
			21: v = 34'sd326;
			22: v = 34'sd163;
			23: v = 34'sd81;
			24: v = 34'sd41;
			25: v = 34'sd20;
			26: v = 34'sd10;
			27: v = 34'sd5;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
		return v[CW-1] ? (~v + CW'(1)) : v;
	endfunction

endpackage

/* hw/rtl/cartesian_to_normalized_spherical.sv */
// Cartesian point to normalized spherical values.
// Input stream: s_axis_tdata carries x_pos, y_pos, z_pos (20-bit signed Q11.8 mm).
// Output stream: m_axis_tdata carries radius_norm (Q5.16, length over 128 mm),
// azimuth_norm = atan2(|x|, y)/pi and elevation_norm = atan2(|z|, y)/pi (Q1.16).
// Every accepted transaction gives exactly one result transaction, in order.
// The pipeline has 24 register stages between s_axis and m_axis: one stage for
// magnitudes, one for the squares, one for the sum, then a digit-by-digit square
// root of one result bit per stage (21 stages); the two angle vectoring CORDICs
// run alongside in 18 stages plus one rounding stage and are delayed to match.
// Throughput is one transaction per cycle while the output is not stalled; the whole
// pipeline advances together whenever its last stage is empty or m_axis_tready is high.
// When the receiver stalls with a result held, the pipeline holds and
// s_axis_tready drops; nothing is lost or repeated.
// The block keeps no state between transactions. Reset (arst_n low,
// asynchronous) empties the pipeline; results in flight are dropped.
module cartesian_to_normalized_spherical
	import c2ns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // x_pos[19:0], y_pos[39:20], z_pos[59:40], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // radius_norm[20:0], azimuth_norm[37:21], elevation_norm[54:38]
);

	logic en;
	logic [NST:1] vld_q;

	logic [CW-1:0] ax_s1, ay_s1, az_s1;
	logic yneg_s1;
	logic [SQW-1:0] sqx_s2, sqy_s2, sqz_s2;

	logic signed [CXW-1:0] crd_x_s [2][CS+1];
	logic signed [CXW-1:0] crd_y_s [2][CS+1];
	logic signed [ZW-1:0] crd_z_s [2][CS+1];
	logic crd_az_s [2][CS+1];
	logic crd_bn_s [2][CS+1];
	logic crd_bz_s [2][CS+1];

	logic [AW-1:0] ang_s [2][NST-CEND];

	logic [SW-1:0] sq_val_s [RW+1];
	logic [REMW-1:0] sq_rem_s [RW+1];
	logic [RW-1:0] sq_root_s [RW+1];

	assign en = !vld_q[NST] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[NST];
	assign m_axis_tdata = {1'b0, ang_s[1][NST-CEND-1], ang_s[0][NST-CEND-1], sq_root_s[RW]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-1:1], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= mag(s_axis_tdata[CW-1:0]);
			ay_s1 <= mag(s_axis_tdata[2*CW-1:CW]);
			az_s1 <= mag(s_axis_tdata[3*CW-1:2*CW]);
			yneg_s1 <= s_axis_tdata[2*CW-1];
			sqx_s2 <= ax_s1 * ax_s1;
			sqy_s2 <= ay_s1 * ay_s1;
			sqz_s2 <= az_s1 * az_s1;
			sq_val_s[0] <= ({2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2}) << 2;
			sq_rem_s[0] <= '0;
			sq_root_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [REMW+1:0] rem2, trial;
		assign rem2 = {sq_rem_s[j], sq_val_s[j][SW-1 -: 2]};
		assign trial = {2'b00, sq_root_s[j], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				sq_val_s[j+1] <= sq_val_s[j] << 2;
				if (rem2 >= trial) begin
					sq_rem_s[j+1] <= REMW'(rem2 - trial);
					sq_root_s[j+1] <= {sq_root_s[j][RW-2:0], 1'b1};
				end else begin
					sq_rem_s[j+1] <= REMW'(rem2);
					sq_root_s[j+1] <= {sq_root_s[j][RW-2:0], 1'b0};
				end
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				crd_x_s[l][0] <= CXW'(ay_s1) << SCALE;
				crd_y_s[l][0] <= CXW'(l == 0 ? ax_s1 : az_s1) << SCALE;
				crd_z_s[l][0] <= '0;
				crd_az_s[l][0] <= (l == 0 ? ax_s1 : az_s1) == '0;
				crd_bn_s[l][0] <= yneg_s1;
				crd_bz_s[l][0] <= ay_s1 == '0;
			end
		end

		for (genvar c = 0; c < CS; c++) begin : g_crd
			logic signed [CXW-1:0] dx, dy;
			assign dx = crd_y_s[l][c] >>> c;
			assign dy = crd_x_s[l][c] >>> c;
			always_ff @(posedge clk) begin
				if (en) begin
					crd_az_s[l][c+1] <= crd_az_s[l][c];
					crd_bn_s[l][c+1] <= crd_bn_s[l][c];
					crd_bz_s[l][c+1] <= crd_bz_s[l][c];
					if (!crd_y_s[l][c][CXW-1]) begin
						crd_x_s[l][c+1] <= crd_x_s[l][c] + dx;
						crd_y_s[l][c+1] <= crd_y_s[l][c] - dy;
						crd_z_s[l][c+1] <= crd_z_s[l][c] + arc_tab(c);
					end else begin
						crd_x_s[l][c+1] <= crd_x_s[l][c] - dx;
						crd_y_s[l][c+1] <= crd_y_s[l][c] + dy;
						crd_z_s[l][c+1] <= crd_z_s[l][c] - arc_tab(c);
					end
				end
			end
		end

		logic signed [ZW-1:0] zc, zf;
		logic [ZW-1:0] zr;
		logic [AW-1:0] ang;
		always_comb begin
			zc = crd_z_s[l][CS];
			if (zc < 0) begin
				zc = '0;
			end
			if (zc > Z_HALF) begin
				zc = Z_HALF;
			end
			zf = crd_bn_s[l][CS] ? (Z_ONE - zc) : zc;
			zr = (ZW'(zf) + Z_RND) >> (31 - FB);
			if (crd_az_s[l][CS]) begin
				ang = crd_bn_s[l][CS] ? ANG_ONE : '0;
			end else if (crd_bz_s[l][CS]) begin
				ang = ANG_HALF;
			end else begin
				ang = zr[AW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ang_s[l][0] <= ang;
				for (int k = 1; k < NST - CEND; k++) begin
					ang_s[l][k] <= ang_s[l][k-1];
				end
			end
		end
	end

endmodule

/* test/tb.sv */
module tb;
	import c2ns_pkg::*;

	class spherical_scoreboard;
		logic [RW-1:0] radius_q[$];
		logic [AW-1:0] azim_q[$];
		logic [AW-1:0] elev_q[$];
		int errors;
		int checked;

		function longint unsigned mag64(logic [CW-1:0] v);
			longint s;
			s = longint'(signed'(v));
			return s < 0 ? longint'(-s) : longint'(s);
		endfunction

		function longint unsigned isqrt(longint unsigned s, int extra);
			longint unsigned rem, root, pr, trial;
			rem = 0;
			root = 0;
			for (int i = 0; i < 32 + extra; i++) begin
				pr = (i < 32) ? ((s >> (62 - 2 * i)) & 64'd3) : 64'd0;
				rem = (rem << 2) | pr;
				trial = (root << 2) | 64'd1;
				if (rem >= trial) begin
					rem = rem - trial;
					root = (root << 1) | 64'd1;
				end else begin
					root = root << 1;
				end
			end
			return root;
		endfunction

		function logic [AW-1:0] arc_norm(longint unsigned a, longint b);
			longint px, py, zacc, dx, dy;
			longint unsigned r;
			int stg;
			zacc = 0;
			if (a == 0) return b < 0 ? ANG_ONE : '0;
			if (b == 0) return ANG_HALF;
			stg = CS > 28 ? 28 : CS;
			px = (b < 0 ? -b : b) <<< SCALE;
			py = longint'(a) <<< SCALE;
			for (int i = 0; i < stg; i++) begin
				dx = py >>> i;
				dy = px >>> i;
				if (py >= 0) begin
					px += dx;
					py -= dy;
					zacc += longint'(arc_tab(i));
				end else begin
					px -= dx;
					py += dy;
					zacc -= longint'(arc_tab(i));
				end
			end
			if (zacc < 0) zacc = 0;
			if (zacc > (64'sd1 << 30)) zacc = 64'sd1 << 30;
			if (b < 0) zacc = (64'sd1 << 31) - zacc;
			r = (longint'(zacc) + (64'd1 << (30 - FB))) >> (31 - FB);
			return AW'(r);
		endfunction

		function void note_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
			longint unsigned ax, ay, az, s, r;
			ax = mag64(x);
			ay = mag64(y);
			az = mag64(z);
			s = ax * ax + ay * ay + az * az;
			if (FB >= 15) r = isqrt(s, FB - 15);
			else r = isqrt(s, 0) >> (15 - FB);
			if (r > ((64'd1 << RW) - 1)) r = (64'd1 << RW) - 1;
			radius_q.push_back(RW'(r));
			azim_q.push_back(arc_norm(ax, longint'(signed'(y))));
			elev_q.push_back(arc_norm(az, longint'(signed'(y))));
		endfunction

		function void check_result(logic [55:0] d);
			logic [RW-1:0] er;
			logic [AW-1:0] ea, ee;
			if (radius_q.size() == 0) begin
				$error("unexpected result transaction %h", d);
				errors++;
				return;
			end
			er = radius_q.pop_front();
			ea = azim_q.pop_front();
			ee = elev_q.pop_front();
			checked++;
			if (d[20:0] !== er) begin
				$error("radius_norm expected %0d actual %0d", er, d[20:0]);
				errors++;
			end
			if (d[37:21] !== ea) begin
				$error("azimuth_norm expected %0d actual %0d", ea, d[37:21]);
				errors++;
			end
			if (d[54:38] !== ee) begin
				$error("elevation_norm expected %0d actual %0d", ee, d[54:38]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [55:0] m_axis_tdata;

	spherical_scoreboard sb = new();
	bit stim_done = 0;
	int idle_cycles = 0;
	int out_wait = 0;

	always #10 clk = ~clk;

	cartesian_to_normalized_spherical uut (.*);

	task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		int gap;
		gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'b0, z, y, x};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_point(x, y, z);
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return CW'($urandom_range(0, 3));
			1: return -CW'($urandom_range(0, 3));
			2: return {1'b1, {(CW-1){1'b0}}};
			3: return CW'($urandom_range(0, 4096)) - CW'(2048);
			default: return CW'($urandom);
		endcase
	endfunction

	initial begin
		int wait_cnt;
		logic [CW-1:0] ext[4];
		ext[0] = '0;
		ext[1] = {1'b0, {(CW-1){1'b1}}};
		ext[2] = {1'b1, {(CW-1){1'b0}}};
		ext[3] = '1;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				send_point(ext[i], ext[j], ext[(i + j) % 4]);
		send_point(CW'(0), CW'(0), CW'(0));
		send_point(CW'(5), CW'(0), -CW'(7));
		send_point(CW'(0), -CW'(9), CW'(0));
		send_point(CW'(300), CW'(300), -CW'(300));
		for (int n = 0; n < 650; n++)
			send_point(rand_coord(), rand_coord(), rand_coord());
		s_axis_tvalid <= 0;
		stim_done = 1;
		while (sb.radius_q.size() != 0) @(posedge clk);
		wait_cnt = 0;
		while (wait_cnt < 40) begin
			@(posedge clk);
			wait_cnt++;
		end
		$display("Checked %0d spherical results over extremes, axis cases and random points.",
			sb.checked);
		if (sb.errors == 0 && sb.radius_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		int w;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata);
				w = $urandom_range(0, 8);
			end else if (out_wait > 0) begin
				w = out_wait - 1;
			end else begin
				w = 0;
			end
			out_wait <= w;
			m_axis_tready <= (w == 0);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("Verification failed");
			$finish;
		end
	end
endmodule

/* cartesian_to_normalized_spherical.f */
hw/rtl/c2ns_pkg.sv
hw/rtl/cartesian_to_normalized_spherical.sv
test/tb.sv
